FILE: rtl/gbi_pkg.sv
package gbi_pkg;

    localparam int IDX_W = 6;
    localparam int VAL_W = 32;
    localparam int CRD_W = 22;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

endpackage

FILE: rtl/gbi_ram.sv
module gbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/grid_bilinear_interpolator_top.sv
// Bilinear interpolator over a ROWS by COLS grid of signed Q16.16 values held in one
// single-port memory. A write transaction (action 0) stores one cell and gives no
// result; writes outside the grid are dropped. A query transaction (action 1) fetches
// the four surrounding cells one per cycle, waits for the last read to land, then runs
// three blends through one shared multiply and add unit, each as a multiply step and an
// add step, and then loads the output register once the output is free; the block
// takes no new transaction until the result is loaded. A query beyond the grid answers
// zero with the out-of-range flag set, without reading the grid. A query that touches
// a cell never written returns an undefined value.
module grid_bilinear_interpolator_top #(
    parameter int ROWS      = 64,
    parameter int COLS      = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_action,
    input  logic [gbi_pkg::IDX_W-1:0]  i_cell_row,
    input  logic [gbi_pkg::IDX_W-1:0]  i_cell_col,
    input  logic signed [gbi_pkg::VAL_W-1:0] i_cell_value,
    input  logic [gbi_pkg::CRD_W-1:0]  i_coord_row,
    input  logic [gbi_pkg::CRD_W-1:0]  i_coord_col,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [gbi_pkg::VAL_W-1:0] o_interpolated,
    output logic                       o_out_of_range
);

    import gbi_pkg::*;

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int XW    = CRD_W + FRAC_BITS;
    localparam int PW    = VAL_W + FRAC_BITS + 2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MUL  = 5'b00100,
        S_ADD  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] r_step, n_step;
    logic       r_rd_pend, n_rd_pend;
    logic       r_out_valid, n_out_valid;

    logic [RW-1:0]        r_r0, n_r0, r_r1, n_r1;
    logic [CW-1:0]        r_c0, n_c0, r_c1, n_c1;
    logic [FRAC_BITS-1:0] r_rf, n_rf, r_cf, n_cf;
    logic signed [VAL_W-1:0] r_p00, n_p00, r_p10, n_p10, r_p01, n_p01, r_p11, n_p11;
    logic signed [VAL_W-1:0] r_f1, n_f1, r_f2, n_f2, r_res, n_res;
    logic signed [VAL_W-1:0] r_a, n_a;
    logic signed [PW-1:0]    r_prod, n_prod;
    logic                    r_bad, n_bad;
    logic signed [VAL_W-1:0] r_interp, n_interp;
    logic                    r_oor, n_oor;

    logic                 in_fire;
    logic [XW-1:0]        crx, ccx;
    logic [CRD_W-1:0]     ri, ci;
    logic [FRAC_BITS-1:0] rf, cf;
    logic [31:0]          ri_ext, ci_ext;
    logic                 bad;
    logic                 wr_in_grid;
    logic                 ram_we;
    logic [AW-1:0]        wr_addr, rd_addr, ram_addr;
    logic [RW-1:0]        rd_row;
    logic [CW-1:0]        rd_col;
    logic [VAL_W-1:0]     ram_rdata;
    logic signed [VAL_W-1:0] op_a, op_b, blend_res;
    logic [FRAC_BITS-1:0] op_f;
    logic signed [VAL_W:0]   diff;
    logic                 out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    assign crx    = XW'(i_coord_row);
    assign ccx    = XW'(i_coord_col);
    assign ri     = crx[XW-1:FRAC_BITS];
    assign ci     = ccx[XW-1:FRAC_BITS];
    assign rf     = crx[FRAC_BITS-1:0];
    assign cf     = ccx[FRAC_BITS-1:0];
    assign ri_ext = 32'(ri);
    assign ci_ext = 32'(ci);
    assign bad    = (ri_ext > 32'(ROWS - 1)) || ((ri_ext == 32'(ROWS - 1)) && (rf != '0))
                 || (ci_ext > 32'(COLS - 1)) || ((ci_ext == 32'(COLS - 1)) && (cf != '0));

    assign wr_in_grid = (32'(i_cell_row) < 32'(ROWS)) && (32'(i_cell_col) < 32'(COLS));
    assign wr_addr    = AW'(32'(i_cell_row) * 32'(COLS) + 32'(i_cell_col));
    assign ram_we     = in_fire && (t_action'(i_action) == ACT_WRITE) && wr_in_grid;

    assign rd_row   = r_cnt[0] ? r_r1 : r_r0;
    assign rd_col   = r_cnt[1] ? r_c1 : r_c0;
    assign rd_addr  = AW'(32'(rd_row) * 32'(COLS) + 32'(rd_col));
    assign ram_addr = (r_state == S_READ) ? rd_addr : wr_addr;

    gbi_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_grid (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_cell_value),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        unique case (r_step)
            2'd0: begin
                op_a = r_p00;
                op_b = r_p10;
                op_f = r_rf;
            end
            2'd1: begin
                op_a = r_p01;
                op_b = r_p11;
                op_f = r_rf;
            end
            default: begin
                op_a = r_f1;
                op_b = r_f2;
                op_f = r_cf;
            end
        endcase
    end

    assign diff      = (VAL_W+1)'(op_b) - (VAL_W+1)'(op_a);
    assign blend_res = r_a + r_prod[FRAC_BITS +: VAL_W];
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_rd_pend   = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_r0 = r_r0;  n_r1 = r_r1;  n_c0 = r_c0;  n_c1 = r_c1;
        n_rf = r_rf;  n_cf = r_cf;
        n_p00 = r_p00; n_p10 = r_p10; n_p01 = r_p01; n_p11 = r_p11;
        n_f1 = r_f1;  n_f2 = r_f2;  n_res = r_res; n_bad = r_bad;
        n_a = r_a;    n_prod = r_prod;
        n_interp = r_interp; n_oor = r_oor;

        if (r_rd_pend) begin
            n_p00 = r_p10;
            n_p10 = r_p01;
            n_p01 = r_p11;
            n_p11 = ram_rdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (t_action'(i_action) == ACT_QUERY)) begin
                    n_r0  = RW'(ri_ext);
                    n_c0  = CW'(ci_ext);
                    n_r1  = RW'(ri_ext) + RW'(rf != '0);
                    n_c1  = CW'(ci_ext) + CW'(cf != '0);
                    n_rf  = rf;
                    n_cf  = cf;
                    n_bad = bad;
                    n_res = '0;
                    n_cnt = '0;
                    n_step = '0;
                    n_state = bad ? S_FIN : S_READ;
                end
            end
            S_READ: begin
                if (!r_cnt[2]) begin
                    n_rd_pend = 1'b1;
                    n_cnt     = r_cnt + 3'd1;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_a    = op_a;
                n_prod = PW'(diff * $signed({1'b0, op_f}));
                n_state = S_ADD;
            end
            S_ADD: begin
                unique case (r_step)
                    2'd0: n_f1 = blend_res;
                    2'd1: n_f2 = blend_res;
                    default: n_res = blend_res;
                endcase
                if (r_step == 2'd2) begin
                    n_state = S_FIN;
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_interp    = r_res;
                    n_oor       = r_bad;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_step      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_step      <= n_step;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r0 <= n_r0;  r_r1 <= n_r1;  r_c0 <= n_c0;  r_c1 <= n_c1;
        r_rf <= n_rf;  r_cf <= n_cf;
        r_p00 <= n_p00; r_p10 <= n_p10; r_p01 <= n_p01; r_p11 <= n_p11;
        r_f1 <= n_f1;  r_f2 <= n_f2;  r_res <= n_res; r_bad <= n_bad;
        r_a <= n_a;    r_prod <= n_prod;
        r_interp <= n_interp; r_oor <= n_oor;
    end

    assign o_out_valid    = r_out_valid;
    assign o_interpolated = r_interp;
    assign o_out_of_range = r_oor;

`ifndef SYNTH
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (o_interpolated == '0))
        else $error("out-of-range result carries a nonzero value");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action) |=> !o_in_ready)
        else $error("query transaction did not hold off the input");

    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_action) |=> (o_in_ready && !$rose(o_out_valid)))
        else $error("write transaction stalled the input or produced a result");

    a_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> ((r_state == S_READ) && !ram_we))
        else $error("grid read outstanding outside the fetch phase");
`endif

endmodule
